// ===== design/plst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the positional list store.
// No dependencies; every other file imports this package.
package plst_pkg;

  localparam int VAL_W     = 32;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 5;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 8;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    cell_op_t                op;
    logic [IDX_W-1:0]        idx;
    logic [IDX_W-1:0]        last_idx;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== design/plst_in_if.sv =====
`timescale 1ns / 1ps
// Command channel of the positional list store: valid/ready plus command payload.
// Depends on plst_pkg.
interface plst_in_if;
  import plst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

// ===== design/plst_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the positional list store: valid/ready plus result payload.
// Depends on plst_pkg.
interface plst_out_if;
  import plst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    status;
  logic signed [VAL_W-1:0] element;
  logic [CNT_W-1:0]        count;
  logic                    last;

  modport source (output valid, status, element, count, last, input ready);
  modport sink   (input valid, status, element, count, last, output ready);
endinterface

// ===== design/plst_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the list row: holds one element and shifts with its neighbors.
// Depends on plst_pkg.
module plst_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  plst_pkg::cell_ctrl_t             ctrl,
  input  logic signed [plst_pkg::VAL_W-1:0] left,
  input  logic signed [plst_pkg::VAL_W-1:0] right,
  input  logic signed [plst_pkg::VAL_W-1:0] wrap,
  output logic signed [plst_pkg::VAL_W-1:0] q
);
  import plst_pkg::*;

  localparam logic [IDX_W-1:0] MY = IDX_W'(IDX);

  logic signed [VAL_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (ctrl.op)
      OP_INS: begin
        if (MY == ctrl.idx) q_next = ctrl.value;
        else if (MY > ctrl.idx) q_next = left;
      end
      OP_DEL: begin
        if (MY >= ctrl.idx) q_next = right;
      end
      OP_ROT: begin
        if (MY == ctrl.last_idx) q_next = wrap;
        else if (MY < ctrl.last_idx) q_next = right;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end
endmodule

// ===== design/positional_list_store_core.sv =====
`timescale 1ns / 1ps
// Positional list store: ordered list of signed 32-bit values in a row of shift cells.
// Depends on plst_pkg, plst_in_if, plst_out_if and plst_cell.
//
// Usage:
//   req (sink): one command per item - insert first/last/at, delete first/last/at, dump.
//   rsp (source): result items with status, element, count and last.
//   Inserts and deletes shift every affected cell at once; each gives one result item
//   registered in the cycle after acceptance, one item per cycle while rsp is ready.
//   A dump first enters the dump state, then rotates the cell row once per cycle while
//   rsp is ready, emitting element 0 each time; its first result passes the state
//   register, then the result register; the next command is accepted as the last
//   result leaves. An empty dump gives one rejected result the cycle after acceptance.
//   The result register frees when rsp takes it, so a new command is accepted in the
//   same cycle the previous result leaves. When rsp stalls, req.ready drops and the
//   dump rotation pauses; nothing is lost.
//   Reset (rst, synchronous) empties the list and drops any pending result; cell
//   contents are not cleared, only cells below the count are ever read.
module positional_list_store_core #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  plst_in_if.sink    req,
  plst_out_if.source rsp
);
  import plst_pkg::*;

  localparam int LENW = $clog2(CAPACITY + 1);
  localparam int CW   = ((LENW > POS_W) ? LENW : POS_W) + 1;

  state_t state, state_next;
  logic [LENW-1:0] length, length_next;
  logic [LENW-1:0] dcnt;

  logic                    out_valid;
  logic                    out_status;
  logic signed [VAL_W-1:0] out_element;
  logic [CNT_W-1:0]        out_count;
  logic                    out_last;

  logic slot_free, take, dump_step, dump_last, dump_start;
  logic ok;
  cell_op_t op_d;
  logic [CW-1:0] idx_c, len_x, pos_x, len_next_x;
  cell_ctrl_t ctrl;

  logic signed [VAL_W-1:0] vals [CAPACITY];

  assign slot_free  = !out_valid || rsp.ready;
  assign take       = req.valid && req.ready;
  assign dump_step  = (state == ST_DUMP) && slot_free;
  assign dump_last  = (dcnt == LENW'(length - 1'b1));
  assign len_x      = CW'(length);
  assign pos_x      = CW'(req.position);
  assign dump_start = take && (cmd_t'(req.cmd) == CMD_DUMP) && (length != '0);

  // command decode
  always_comb begin
    ok    = 1'b0;
    op_d  = OP_HOLD;
    idx_c = '0;
    case (cmd_t'(req.cmd))
      CMD_INS_FIRST: begin
        ok   = (len_x < CW'(CAPACITY));
        op_d = OP_INS;
      end
      CMD_INS_LAST: begin
        ok    = (len_x < CW'(CAPACITY));
        op_d  = OP_INS;
        idx_c = len_x;
      end
      CMD_INS_AT: begin
        ok    = (len_x != '0) && (len_x < CW'(CAPACITY)) && (pos_x != '0)
                && (pos_x <= len_x + 1'b1);
        op_d  = OP_INS;
        idx_c = pos_x - 1'b1;
      end
      CMD_DEL_FIRST: begin
        ok   = (len_x != '0);
        op_d = OP_DEL;
      end
      CMD_DEL_LAST: begin
        ok    = (len_x != '0);
        op_d  = OP_DEL;
        idx_c = len_x - 1'b1;
      end
      CMD_DEL_AT: begin
        ok    = (pos_x != '0) && (pos_x <= len_x);
        op_d  = OP_DEL;
        idx_c = pos_x - 1'b1;
      end
      CMD_DUMP: begin
        ok = (len_x != '0);
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    length_next = length;
    if (take && ok && (op_d == OP_INS)) length_next = length + 1'b1;
    else if (take && ok && (op_d == OP_DEL)) length_next = length - 1'b1;
  end

  assign len_next_x = CW'(length_next);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (dump_start) state_next = ST_DUMP;
      ST_DUMP: if (dump_step && dump_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready     = 1'b0;
    ctrl.op       = OP_HOLD;
    ctrl.idx      = IDX_W'(idx_c);
    ctrl.last_idx = IDX_W'(length - 1'b1);
    ctrl.value    = req.value;
    case (state)
      ST_IDLE: begin
        req.ready = slot_free;
        if (take && ok) ctrl.op = op_d;
      end
      ST_DUMP: begin
        if (dump_step) ctrl.op = OP_ROT;
      end
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      length <= '0;
      dcnt   <= '0;
    end else begin
      state  <= state_next;
      length <= length_next;
      if (dump_start) dcnt <= '0;
      else if (dump_step) dcnt <= dcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= !dump_start;
    end else if (dump_step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status  <= !ok;
      out_element <= '0;
      out_count   <= len_next_x[CNT_W-1:0];
      out_last    <= 1'b1;
    end else if (dump_step) begin
      out_status  <= 1'b0;
      out_element <= vals[0];
      out_count   <= len_x[CNT_W-1:0];
      out_last    <= dump_last;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.element = out_element;
  assign rsp.count   = out_count;
  assign rsp.last    = out_last;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_d = vals[g];
    end else begin : g_inner
      assign right_d = vals[g+1];
    end
    plst_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left_d),
      .right (right_d),
      .wrap  (vals[0]),
      .q     (vals[g])
    );
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LENW'(CAPACITY))
    else $error("list length above capacity");

  a_dump_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_DUMP |-> !req.ready)
    else $error("command accepted during dump");

  a_dump_enter: assert property (@(posedge clk) disable iff (rst)
    dump_start |=> state == ST_DUMP && !rsp.valid)
    else $error("dump did not start");

  a_partial_in_dump: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.last |-> state == ST_DUMP)
    else $error("non-final result outside dump");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_store_core: directed table, then random traffic.
// Depends on plst_pkg, plst_in_if, plst_out_if and the design files.
module tb_top;
  import plst_pkg::*;

  localparam int LIST_CAP   = CAPACITY_DEF;
  localparam int CYCLE_CAP  = 400000;
  localparam int TAIL_WAIT  = 20;
  localparam int RAND_ITEMS = 111;

  typedef struct packed {
    logic                    status;
    logic signed [VAL_W-1:0] element;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } list_result_t;

  typedef struct packed {
    cmd_t                    op;
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    logic [4:0]              reps;
    logic                    typed;
    logic                    t_status;
    logic [CNT_W-1:0]        t_count;
  } step_row_t;

  localparam int NUM_ROWS = 25;
  localparam step_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{CMD_DEL_FIRST, 32'sd0,          5'd0,  5'd1,  1'b1, 1'b1, 5'd0},
    '{CMD_DUMP,      32'sd0,          5'd0,  5'd1,  1'b1, 1'b1, 5'd0},
    '{CMD_INS_AT,    32'sd7,          5'd1,  5'd1,  1'b1, 1'b1, 5'd0},
    '{CMD_DEL_AT,    32'sd0,          5'd0,  5'd1,  1'b1, 1'b1, 5'd0},
    '{CMD_DEL_AT,    32'sd0,          5'd1,  5'd1,  1'b1, 1'b1, 5'd0},
    '{CMD_DEL_LAST,  32'sd0,          5'd0,  5'd1,  1'b1, 1'b1, 5'd0},
    '{CMD_INS_FIRST, 32'h7FFF_FFFF,   5'd0,  5'd1,  1'b1, 1'b0, 5'd1},
    '{CMD_DEL_LAST,  32'sd0,          5'd0,  5'd1,  1'b1, 1'b0, 5'd0},
    '{CMD_INS_LAST,  32'h8000_0000,   5'd0,  5'd1,  1'b1, 1'b0, 5'd1},
    '{CMD_INS_AT,    32'hFFFF_FFFF,   5'd2,  5'd1,  1'b1, 1'b0, 5'd2},
    '{CMD_INS_AT,    32'sd5,          5'd0,  5'd1,  1'b1, 1'b1, 5'd2},
    '{CMD_INS_AT,    32'sd5,          5'd4,  5'd1,  1'b1, 1'b1, 5'd2},
    '{CMD_INS_AT,    32'sd0,          5'd1,  5'd1,  1'b1, 1'b0, 5'd3},
    '{CMD_DEL_AT,    32'sd0,          5'd4,  5'd1,  1'b1, 1'b1, 5'd3},
    '{CMD_DEL_AT,    32'sd0,          5'd2,  5'd1,  1'b1, 1'b0, 5'd2},
    '{CMD_DUMP,      32'sd0,          5'd0,  5'd1,  1'b0, 1'b0, 5'd0},
    '{CMD_INS_LAST,  32'h1234_5678,   5'd0,  5'd14, 1'b0, 1'b0, 5'd0},
    '{CMD_INS_FIRST, 32'sd1,          5'd0,  5'd1,  1'b1, 1'b1, 5'd16},
    '{CMD_INS_AT,    32'sd2,          5'd17, 5'd1,  1'b1, 1'b1, 5'd16},
    '{CMD_INS_LAST,  32'sd3,          5'd0,  5'd1,  1'b1, 1'b1, 5'd16},
    '{CMD_DUMP,      32'sd0,          5'd0,  5'd1,  1'b0, 1'b0, 5'd0},
    '{CMD_DEL_AT,    32'sd0,          5'd31, 5'd1,  1'b1, 1'b1, 5'd16},
    '{CMD_DEL_AT,    32'sd0,          5'd16, 5'd1,  1'b1, 1'b0, 5'd15},
    '{CMD_DEL_FIRST, 32'sd0,          5'd0,  5'd1,  1'b1, 1'b0, 5'd14},
    '{CMD_DUMP,      32'sd0,          5'd0,  5'd1,  1'b0, 1'b0, 5'd0}
  };

  logic clk;
  logic rst;

  plst_in_if  req_if ();
  plst_out_if rsp_if ();

  positional_list_store_core #(.CAPACITY(LIST_CAP)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic signed [VAL_W-1:0] list_vals[$];
  list_result_t            pending_results[$];

  int  src_idle_pct = 7;
  int  rsp_stall_pct = 87;
  int  error_count = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  dumps_done = 0;
  int  full_rejects = 0;
  int  max_len = 0;
  bit  grow_mode = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void apply_list_cmd(cmd_t op, logic signed [VAL_W-1:0] v,
                                         logic [POS_W-1:0] p);
    int           n;
    bit           ok;
    list_result_t res;
    n  = list_vals.size();
    ok = 1'b0;
    case (op)
      CMD_INS_FIRST: begin
        if (n < LIST_CAP) begin
          list_vals.push_front(v);
          ok = 1'b1;
        end
      end
      CMD_INS_LAST: begin
        if (n < LIST_CAP) begin
          list_vals.push_back(v);
          ok = 1'b1;
        end
      end
      CMD_INS_AT: begin
        if (n < LIST_CAP && n != 0 && p >= 1 && p <= n + 1) begin
          list_vals.insert(p - 1, v);
          ok = 1'b1;
        end
      end
      CMD_DEL_FIRST: begin
        if (n != 0) begin
          void'(list_vals.pop_front());
          ok = 1'b1;
        end
      end
      CMD_DEL_LAST: begin
        if (n != 0) begin
          void'(list_vals.pop_back());
          ok = 1'b1;
        end
      end
      CMD_DEL_AT: begin
        if (p >= 1 && p <= n) begin
          list_vals.delete(p - 1);
          ok = 1'b1;
        end
      end
      CMD_DUMP: begin
        dumps_done++;
        if (n == 0) begin
          res = '{status: 1'b1, element: '0, count: '0, last: 1'b1};
          pending_results.push_back(res);
        end else begin
          for (int i = 0; i < n; i++) begin
            res = '{status: 1'b0, element: list_vals[i], count: CNT_W'(n),
                    last: (i == n - 1)};
            pending_results.push_back(res);
          end
        end
        return;
      end
      default: ok = 1'b0;
    endcase
    if (!ok && n == LIST_CAP && (op == CMD_INS_FIRST || op == CMD_INS_LAST || op == CMD_INS_AT))
      full_rejects++;
    if (list_vals.size() > max_len) max_len = list_vals.size();
    res = '{status: !ok, element: '0, count: CNT_W'(list_vals.size()), last: 1'b1};
    pending_results.push_back(res);
  endfunction

  task automatic send_cmd(cmd_t op, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p,
                          logic typed, logic t_status, logic [CNT_W-1:0] t_count);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.cmd      <= op;
    req_if.value    <= v;
    req_if.position <= p;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    apply_list_cmd(op, v, p);
    if (typed)
      pending_results[pending_results.size() - 1] =
        '{status: t_status, element: '0, count: t_count, last: 1'b1};
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_cmd();
    int                      n;
    int                      r;
    cmd_t                    op;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0]        p;
    n = list_vals.size();
    if ($urandom_range(29) == 0) grow_mode = !grow_mode;
    r = $urandom_range(99);
    if (r < 8)
      op = CMD_DUMP;
    else if (r < (grow_mode ? 70 : 38))
      op = cmd_t'($urandom_range(2));
    else
      op = cmd_t'(3 + $urandom_range(2));
    case ($urandom_range(19))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'hFFFF_FFFF;
      3: v = '0;
      default: v = $urandom;
    endcase
    p = POS_W'($urandom_range(31));
    if ($urandom_range(99) < 85) begin
      if (op == CMD_INS_AT) p = POS_W'($urandom_range(n + 1, 1));
      else if (op == CMD_DEL_AT && n != 0) p = POS_W'($urandom_range(n, 1));
    end
    send_cmd(op, v, p, 1'b0, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("unexpected result item: status %0d element %0d count %0d last %0d",
                 rsp_if.status, rsp_if.element, rsp_if.count, rsp_if.last);
          error_count++;
        end else begin
          list_result_t want;
          want = pending_results.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            error_count++;
          end
          if (rsp_if.element !== want.element) begin
            $error("element: expected %0d, actual %0d", want.element, rsp_if.element);
            error_count++;
          end
          if (rsp_if.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp_if.count);
            error_count++;
          end
          if (rsp_if.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, rsp_if.last);
            error_count++;
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.cmd      = CMD_INS_FIRST;
    req_if.value    = '0;
    req_if.position = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int k = 0; k < DIRECTED_ROWS[i].reps; k++)
        send_cmd(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].val + k, DIRECTED_ROWS[i].pos,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].t_status,
                 DIRECTED_ROWS[i].t_count);
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 7 : (ph == 1) ? 87 : 0;
      rsp_stall_pct = (ph == 0) ? 87 : (ph == 1) ? 7 : 0;
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (ph == 1 && i == 60) wait_for_drain();
        send_random_cmd();
      end
      wait_for_drain();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      error_count++;
    end

    $display("Covered %0d commands and %0d result items, %0d dumps included.",
             items_sent, results_checked, dumps_done);
    $display("Deepest list %0d of %0d entries; %0d inserts refused on a full store.",
             max_len, LIST_CAP, full_rejects);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
